FILE: hw/rtl/label_boundary_outline_unit_macros.svh
`ifndef LABEL_BOUNDARY_OUTLINE_UNIT_MACROS_SVH
`define LABEL_BOUNDARY_OUTLINE_UNIT_MACROS_SVH

`ifndef SYNTH
`define LBO_ASSERT_NOW(name, clock, reset, cond, expr) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("lbo assertion failed");
`define LBO_ASSERT_NEXT(name, clock, reset, cond, expr) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("lbo assertion failed");
`else
`define LBO_ASSERT_NOW(name, clock, reset, cond, expr)
`define LBO_ASSERT_NEXT(name, clock, reset, cond, expr)
`endif

`endif

FILE: hw/rtl/lbo_pkg.sv
package lbo_pkg;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int COL_W    = 10;
  localparam int LABEL_W  = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [WIDTH_W-1:0]  MAX_WIDTH    = 11'd1024;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 11'd3;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 16'd2;
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd1024;

  localparam logic [LABEL_W-1:0] OUTLINE_COLOR    = 32'hFF00_FF00;
  localparam logic [LABEL_W-1:0] BACKGROUND_COLOR = 32'h0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [LABEL_W-1:0] up;
    logic [LABEL_W-1:0] mid;
  } line_entry_t;

  typedef struct packed {
    logic [LABEL_W-1:0] ctr;
    logic [LABEL_W-1:0] up;
    logic [LABEL_W-1:0] left;
    logic [LABEL_W-1:0] right;
    logic [LABEL_W-1:0] down;
    logic               border;
  } window_t;

  typedef struct packed {
    logic               emit;
    logic               write;
    logic               border;
    logic               frame_end;
    logic [COL_W-1:0]   col;
    logic [LABEL_W-1:0] lab;
  } stage_t;

endpackage

FILE: hw/rtl/lbo_stencil.sv
module lbo_stencil (
  input  lbo_pkg::window_t           win,
  output logic [lbo_pkg::LABEL_W-1:0] pixel
);

  logic on;

  always_comb begin
    if (win.border) begin
      on = (win.ctr != '0);
    end else begin
      on = (win.ctr != '0) &&
           ((win.left != win.ctr) || (win.right != win.ctr) ||
            (win.up != win.ctr) || (win.down != win.ctr));
    end
    pixel = on ? lbo_pkg::OUTLINE_COLOR : lbo_pkg::BACKGROUND_COLOR;
  end

endmodule

FILE: hw/rtl/label_boundary_outline_unit.sv
// out_valid rises once the item that completes a result (pixel of the next row,
// or a drain item for the last row) has passed stage s1 into the output register.
// Throughput: one item per cycle while the output is not stalled; each item reads
// ahead one entry of the 1024 x 64 line memory (upper and middle row per column),
// each pixel item writes one back. Reset clears counters, handshake state and
// registers to 1024 x 1024, not the line memory; stale entries reach no output.
`include "label_boundary_outline_unit_macros.svh"

module label_boundary_outline_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lbo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbo_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [lbo_pkg::LABEL_W-1:0]       label,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lbo_pkg::LABEL_W-1:0]       out_pixel,
  output logic                              frame_end
);

  logic [lbo_pkg::WIDTH_W-1:0]  image_width;
  logic [lbo_pkg::HEIGHT_W-1:0] image_height;
  logic [lbo_pkg::WIDTH_W-1:0]  w_use;
  logic [lbo_pkg::HEIGHT_W-1:0] h_use;

  logic [lbo_pkg::COL_W-1:0]    col;
  logic [lbo_pkg::COL_W-1:0]    col_next;
  logic [lbo_pkg::HEIGHT_W-1:0] row;
  logic                         draining;
  logic                         last_col;

  logic in_fire;
  logic take_pixel;
  logic take_drain;
  logic mem_re;
  logic mem_we;

  lbo_pkg::line_entry_t line_mem [lbo_pkg::MAX_WIDTH];
  lbo_pkg::line_entry_t rd_data;
  lbo_pkg::line_entry_t cur;
  lbo_pkg::line_entry_t wr_data;
  logic [lbo_pkg::LABEL_W-1:0] left;

  logic            s1_v;
  lbo_pkg::stage_t s1;
  logic            s1_fire;

  lbo_pkg::window_t            win;
  logic [lbo_pkg::LABEL_W-1:0] pixel;

  always_comb begin
    w_use = image_width;
    if (w_use < lbo_pkg::MIN_WIDTH) w_use = lbo_pkg::MIN_WIDTH;
    if (w_use > lbo_pkg::MAX_WIDTH) w_use = lbo_pkg::MAX_WIDTH;
    h_use = image_height;
    if (h_use < lbo_pkg::MIN_HEIGHT) h_use = lbo_pkg::MIN_HEIGHT;
  end

  assign draining = (row >= h_use);
  assign last_col = (({1'b0, col} + lbo_pkg::WIDTH_W'(1)) >= w_use);
  assign col_next = last_col ? '0 : col + lbo_pkg::COL_W'(1);

  assign s1_fire    = s1_v && (!s1.emit || !out_valid || out_ready);
  assign in_ready   = !s1_v || s1_fire;
  assign in_fire    = in_valid && in_ready;
  assign take_pixel = in_fire && (command == lbo_pkg::CMD_PIXEL) && !draining;
  assign take_drain = in_fire && (command == lbo_pkg::CMD_DRAIN) && draining;
  assign mem_re     = take_pixel || take_drain;
  assign mem_we     = s1_fire && s1.write;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lbo_pkg::RESET_WIDTH;
      image_height <= lbo_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbo_pkg::REG_WIDTH:  image_width  <= cfg_data[lbo_pkg::WIDTH_W-1:0];
        lbo_pkg::REG_HEIGHT: image_height <= cfg_data[lbo_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // advance input position; restart on any register write or after the last drain
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col <= '0;
      row <= '0;
    end else if (take_pixel) begin
      col <= col_next;
      if (last_col) row <= row + lbo_pkg::HEIGHT_W'(1);
    end else if (take_drain) begin
      col <= col_next;
      if (last_col) row <= '0;
    end
  end

  // line memory: read the next column ahead, write back the finished column
  assign wr_data.up  = cur.mid;
  assign wr_data.mid = s1.lab;

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[s1.col] <= wr_data;
    if (mem_re) rd_data <= line_mem[col_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (mem_re) begin
      s1_v <= 1'b1;
    end else if (s1_fire) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      s1.emit      <= take_drain || (row != '0);
      s1.write     <= take_pixel;
      s1.border    <= take_drain || (row == lbo_pkg::HEIGHT_W'(1)) ||
                      (col == '0) || last_col;
      s1.frame_end <= take_drain && last_col;
      s1.col       <= col;
      s1.lab       <= label;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) cur <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      left <= '0;
    end else if (mem_we) begin
      left <= cur.mid;
    end
  end

  assign win.ctr    = cur.mid;
  assign win.up     = cur.up;
  assign win.left   = left;
  assign win.right  = rd_data.mid;
  assign win.down   = s1.lab;
  assign win.border = s1.border;

  lbo_stencil u_stencil (
    .win   (win),
    .pixel (pixel)
  );

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.emit) begin
      out_pixel <= pixel;
      frame_end <= s1.frame_end;
    end
  end

  `LBO_ASSERT_NEXT(a_result_lands, clk, rst, s1_fire && s1.emit, out_valid)
  `LBO_ASSERT_NOW(a_col_in_row, clk, rst, 1'b1, ({1'b0, col} < w_use))
  `LBO_ASSERT_NOW(a_row_bounded, clk, rst, 1'b1, (row <= h_use))

endmodule
